// File: rtl/u16u8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg: shared types and constants of the UTF-16 to UTF-8 transcoder
// Code unit ranges, the queue entry that passes from the front to the back,
// and the UTF-8 byte encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OCNT_W  = 32;
  localparam int unsigned HELD_W  = 10;

  localparam logic [UNIT_W-1:0] HIGH_MIN = 16'hD800;
  localparam logic [UNIT_W-1:0] HIGH_MAX = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LOW_MIN  = 16'hDC00;
  localparam logic [UNIT_W-1:0] LOW_MAX  = 16'hDFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;

  localparam logic [CP_W-1:0] MAX_1B = 21'h00007F;
  localparam logic [CP_W-1:0] MAX_2B = 21'h0007FF;
  localparam logic [CP_W-1:0] MAX_3B = 21'h00FFFF;

  localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_B  = 8'h80;

  // One queued result group: either the bytes of one character or one error.
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;      // bytes[0] is the lead byte
    logic [1:0]             last_idx;   // index of the final byte
    logic                   error;
    logic [OCNT_W-1:0]      char_count;
  } entry_t;

  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [1:0]             last_idx;
  } enc_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic enc_t encode(input logic [CP_W-1:0] cp);
    enc_t e;
    e = '0;
    if (cp <= MAX_1B) begin
      e.bytes[0] = {1'b0, cp[6:0]};
      e.last_idx = 2'd0;
    end else if (cp <= MAX_2B) begin
      e.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
      e.bytes[1] = CONT_B | {2'b00, cp[5:0]};
      e.last_idx = 2'd1;
    end else if (cp <= MAX_3B) begin
      e.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
      e.bytes[1] = CONT_B | {2'b00, cp[11:6]};
      e.bytes[2] = CONT_B | {2'b00, cp[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
      e.bytes[1] = CONT_B | {2'b00, cp[17:12]};
      e.bytes[2] = CONT_B | {2'b00, cp[11:6]};
      e.bytes[3] = CONT_B | {2'b00, cp[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// File: rtl/u16u8_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8 channel interfaces
// Valid/ready channels for code units in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        first;

  modport source (output valid, output code_unit, output first, input ready);
  modport sink   (input valid, input code_unit, input first, output ready);
endinterface

interface u16u8_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last;
  logic        error;
  logic [31:0] char_count;

  modport source (output valid, output out_byte, output last, output error,
                  output char_count, input ready);
  modport sink   (input valid, input out_byte, input last, input error,
                  input char_count, output ready);
endinterface
`default_nettype wire

// File: rtl/utf16_to_utf8_transcoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder: UTF-16 code units in, UTF-8 bytes out
// Top level: front stage, result queue and byte sender.
// ----------------------------------------------------------------------------
// The in_ch channel takes one UTF-16 code unit per beat; first marks the
// opening unit of a string and clears the count and any held surrogate.
// The out_ch channel gives one UTF-8 byte per beat, lead byte first, with
// last on the final byte of each character. An unpaired low surrogate or a
// high surrogate after a held high one gives a single error beat (byte 0,
// last and error set). Every beat carries the running character count.
//
// A high surrogate is held in the front and gives no beat at all. A code
// unit accepted by the front goes through the queue and then the output
// register. The byte sender moves one byte per cycle while the receiver
// takes beats; an item gives one to four bytes, set by its UTF-8 length;
// the front accepts a unit every cycle while the queue of FIFO_DEPTH result
// groups has room. When the receiver stalls, the output beat holds, the
// queue fills and then in_ch.ready drops. The synchronous reset empties the
// queue, drops the output beat and clears the held surrogate and the count.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned FIFO_DEPTH  = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  u16u8_in_if.sink    in_ch,
  u16u8_out_if.source out_ch
);

  fifo_stat_t stat;
  entry_t     push_entry;
  entry_t     head;
  logic       push;
  logic       pop;

  // Front: surrogate pairing, classification and encoding.
  u16u8_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .stat      (stat),
    .push      (push),
    .push_entry(push_entry)
  );

  // Queue of whole result groups, so either side can stall on its own.
  u16u8_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  // Back: one byte per beat into the output register.
  u16u8_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .stat  (stat),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule
`default_nettype wire

// File: rtl/u16u8_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_front: input stage
// Accepts code units, pairs surrogates, keeps the character count and pushes
// one encoded character or one error per result group into the queue.
// ----------------------------------------------------------------------------
module u16u8_front
  import u16u8_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  u16u8_in_if.sink        in_ch,
  input  wire fifo_stat_t stat,
  output logic            push,
  output entry_t          push_entry
);

  logic                   held_valid;
  logic [HELD_W-1:0]      held_high;
  logic [COUNT_WIDTH-1:0] chars_done;

  logic                   accept;
  logic                   hv;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] chars_done_next;
  logic                   is_high;
  logic                   is_low;
  logic                   do_hold;
  logic                   do_error;
  logic [CP_W-1:0]        cp;
  logic [63:0]            cnt_wide;
  enc_t                   enc;

  assign in_ch.ready = !stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // A new string drops the held surrogate and restarts the count.
  assign hv  = held_valid && !in_ch.first;
  assign cnt = in_ch.first ? '0 : chars_done;

  assign is_high = (in_ch.code_unit >= HIGH_MIN) && (in_ch.code_unit <= HIGH_MAX);
  assign is_low  = (in_ch.code_unit >= LOW_MIN) && (in_ch.code_unit <= LOW_MAX);

  assign do_hold  = !hv && is_high;
  assign do_error = hv ? is_high : is_low;

  always_comb begin
    if (hv && is_low) begin
      cp = SUPP_BASE + {1'b0, held_high, in_ch.code_unit[9:0]};
    end else begin
      cp = {5'b00000, in_ch.code_unit};
    end
  end

  assign enc     = encode(cp);
  assign cnt_inc = cnt + 1'b1;

  assign chars_done_next = (do_hold || do_error) ? cnt : cnt_inc;
  assign cnt_wide        = 64'(chars_done_next);

  always_comb begin
    push_entry.bytes      = do_error ? '0 : enc.bytes;
    push_entry.last_idx   = do_error ? 2'd0 : enc.last_idx;
    push_entry.error      = do_error;
    push_entry.char_count = cnt_wide[OCNT_W-1:0];
  end

  assign push = accept && !do_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_high  <= '0;
      chars_done <= '0;
    end else if (accept) begin
      held_valid <= do_hold;
      held_high  <= do_hold ? in_ch.code_unit[HELD_W-1:0] : '0;
      chars_done <= chars_done_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/u16u8_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_fifo: result group queue
// Short first-in first-out queue between the front and the back. The head
// entry is visible without a read latency.
// ----------------------------------------------------------------------------
module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output fifo_stat_t  stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/u16u8_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_back: byte sender
// Walks the head queue entry one byte a cycle, when not stalled, into a registered output beat.
// ----------------------------------------------------------------------------
module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire entry_t     head,
  input  wire fifo_stat_t stat,
  output logic            pop,
  u16u8_out_if.source     out_ch
);

  logic       idx;
  logic [1:0] byte_idx;
  logic       load;
  logic       take;
  logic       is_last;

  assign load    = !out_ch.valid || out_ch.ready;
  assign take    = load && !stat.empty;
  assign is_last = (byte_idx == head.last_idx);
  assign pop     = take && is_last;
  assign idx     = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      byte_idx     <= '0;
    end else if (load) begin
      out_ch.valid <= !stat.empty;
      if (take) begin
        byte_idx <= is_last ? 2'd0 : byte_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.out_byte   <= head.bytes[byte_idx];
      out_ch.last       <= is_last | idx;
      out_ch.error      <= head.error;
      out_ch.char_count <= head.char_count;
    end
  end

endmodule
`default_nettype wire

// File: rtl/u16u8_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_chk: port checker
// Watches the output channel of the transcoder and is bound to its top level.
// ----------------------------------------------------------------------------
module u16u8_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        out_last,
  input wire logic        out_error,
  input wire logic [31:0] out_char_count
);

  // A stalled beat stays on the channel.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // An error beat is a single zero byte that closes its group.
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_last && (out_byte == 8'h00))
    else $error("malformed error beat");

  // The bytes of one character follow without a gap and are continuations.
  a_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid && (out_byte[7:6] == 2'b10))
    else $error("character bytes interrupted");

  // The count is the same on every byte of one character.
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_char_count == $past(out_char_count))
    else $error("count changed inside a character");

endmodule

bind utf16_to_utf8_transcoder u16u8_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .out_last      (out_ch.last),
  .out_error     (out_ch.error),
  .out_char_count(out_ch.char_count)
);
`default_nettype wire

// File: tb/utf8_stream_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_checker: predicts and checks the UTF-8 beat stream
// Watches the code unit and byte channels, keeps its own copy of the
// surrogate and character count state, and compares every output beat.
// ----------------------------------------------------------------------------
module utf8_stream_checker
  import u16u8_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  u16u8_in_if         units,
  u16u8_out_if        utf8,
  output int unsigned miss_count,
  output int unsigned backlog,
  output int unsigned beats_checked,
  output int unsigned error_beats
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              fin;
    logic              bad;
    logic [OCNT_W-1:0] count;
  } utf8_beat_t;

  utf8_beat_t        utf8_due[$];
  logic [HELD_W-1:0] held_bits;
  logic              held_ok;
  logic [OCNT_W-1:0] chars;

  initial begin
    miss_count    = 0;
    backlog       = 0;
    beats_checked = 0;
    error_beats   = 0;
    held_bits     = '0;
    held_ok       = 1'b0;
    chars         = '0;
  end

  task automatic push_error();
    held_ok   = 1'b0;
    held_bits = '0;
    utf8_due.push_back('{8'h00, 1'b1, 1'b1, chars});
  endtask

  task automatic push_char(input logic [CP_W-1:0] cp);
    logic [BYTE_W-1:0] b [4];
    int                n;
    b = '{default: '0};
    if (cp <= MAX_1B) begin
      b[0] = {1'b0, cp[6:0]};
      n = 1;
    end else if (cp <= MAX_2B) begin
      b[0] = LEAD_2B | {3'b000, cp[10:6]};
      b[1] = CONT_B | {2'b00, cp[5:0]};
      n = 2;
    end else if (cp <= MAX_3B) begin
      b[0] = LEAD_3B | {4'b0000, cp[15:12]};
      b[1] = CONT_B | {2'b00, cp[11:6]};
      b[2] = CONT_B | {2'b00, cp[5:0]};
      n = 3;
    end else begin
      b[0] = LEAD_4B | {5'b00000, cp[20:18]};
      b[1] = CONT_B | {2'b00, cp[17:12]};
      b[2] = CONT_B | {2'b00, cp[11:6]};
      b[3] = CONT_B | {2'b00, cp[5:0]};
      n = 4;
    end
    chars = chars + 1'b1;
    for (int k = 0; k < n; k++) begin
      utf8_due.push_back('{b[k], (k == n - 1), 1'b0, chars});
    end
  endtask

  // One accepted code unit: update the surrogate state and queue its beats.
  task automatic transcode_unit(input logic [UNIT_W-1:0] cu, input logic opens);
    logic            hi_unit;
    logic            lo_unit;
    logic [CP_W-1:0] cp;
    if (opens) begin
      held_ok   = 1'b0;
      held_bits = '0;
      chars     = '0;
    end
    hi_unit = (cu >= HIGH_MIN) && (cu <= HIGH_MAX);
    lo_unit = (cu >= LOW_MIN) && (cu <= LOW_MAX);
    if (held_ok) begin
      cp        = SUPP_BASE + {1'b0, held_bits, 10'b0} + {11'b0, cu[9:0]};
      held_ok   = 1'b0;
      held_bits = '0;
      if (lo_unit) push_char(cp);
      else if (hi_unit) push_error();
      else push_char({5'b0, cu});
    end else if (hi_unit) begin
      held_bits = cu[9:0];
      held_ok   = 1'b1;
    end else if (lo_unit) begin
      push_error();
    end else begin
      push_char({5'b0, cu});
    end
  endtask

  task automatic check_beat();
    utf8_beat_t want;
    utf8_beat_t got;
    got = '{utf8.out_byte, utf8.last, utf8.error, utf8.char_count};
    if (utf8_due.size() == 0) begin
      miss_count++;
      $display("%0t: beat with nothing expected: got byte=%02h last=%0b error=%0b count=%0d",
               $time, got.data, got.fin, got.bad, got.count);
    end else begin
      want = utf8_due.pop_front();
      beats_checked++;
      if (want.bad) error_beats++;
      if (got.data !== want.data || got.fin !== want.fin ||
          got.bad !== want.bad || got.count !== want.count) begin
        miss_count++;
        $display("%0t: mismatch: expected byte=%02h last=%0b error=%0b count=%0d, got byte=%02h last=%0b error=%0b count=%0d",
                 $time, want.data, want.fin, want.bad, want.count,
                 got.data, got.fin, got.bad, got.count);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      utf8_due.delete();
      held_ok   = 1'b0;
      held_bits = '0;
      chars     = '0;
    end else begin
      if (utf8.valid && utf8.ready) check_beat();
      if (units.valid && units.ready) transcode_unit(units.code_unit, units.first);
    end
    backlog = utf8_due.size();
  end

endmodule
`default_nettype wire

// File: tb/utf16_to_utf8_transcoder_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_test: top of the transcoder testbench
// Drives UTF-16 code units into the block, paces the byte receiver, and
// leaves prediction and comparison to the stream checker beside the block.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_test;
  import u16u8_pkg::*;

  logic clk;
  logic rst;

  // Code units go in on unit_if, UTF-8 beats come back on utf8_if.
  u16u8_in_if  unit_if ();
  u16u8_out_if utf8_if ();

  utf16_to_utf8_transcoder dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (unit_if),
    .out_ch (utf8_if)
  );

  int unsigned miss_count;
  int unsigned backlog;
  int unsigned beats_checked;
  int unsigned error_beats;

  // The checker sees the same handshakes as the block and keeps the score.
  utf8_stream_checker utf8_watch (
    .clk           (clk),
    .rst           (rst),
    .units         (unit_if),
    .utf8          (utf8_if),
    .miss_count    (miss_count),
    .backlog       (backlog),
    .beats_checked (beats_checked),
    .error_beats   (error_beats)
  );

  // Percent of cycles in which the sender holds back, and in which the
  // receiver refuses a beat. The main sequence changes them per phase.
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned units_sent;

  // Registered copy of the input handshake. It is written at the rising
  // edge and read by the driver at the falling edge, so the driver always
  // sees whether its beat was taken at the edge just passed.
  logic unit_took;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) unit_took <= unit_if.valid && unit_if.ready;

  // The receiver decides at every falling edge whether to take a beat.
  initial utf8_if.ready = 1'b0;
  always @(negedge clk) utf8_if.ready <= ($urandom_range(99) >= recv_idle);

  // Hard stop in case the block hangs or loses beats.
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one code unit and wait until it is accepted. Called at a falling
  // edge, returns at the falling edge after the accepting rising edge with
  // valid still high, so back-to-back beats keep valid up without a glitch.
  task automatic send_unit(input logic [15:0] cu, input logic opens);
    while ($urandom_range(99) < send_idle) begin
      unit_if.valid = 1'b0;
      @(negedge clk);
    end
    unit_if.valid     = 1'b1;
    unit_if.code_unit = cu;
    unit_if.first     = opens;
    @(negedge clk);
    while (!unit_took) @(negedge clk);
    units_sent++;
  endtask

  // Hold the sender until the checker has nothing left outstanding.
  task automatic wait_drained();
    unit_if.valid = 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_bmp3();
    if ($urandom_range(1) == 0) return 16'($urandom_range(16'h0800, 16'hD7FF));
    return 16'($urandom_range(16'hE000, 16'hFFFF));
  endfunction

  function automatic logic [15:0] rand_high();
    return HIGH_MIN | 16'($urandom_range(10'h3FF));
  endfunction

  function automatic logic [15:0] rand_low();
    return LOW_MIN | 16'($urandom_range(10'h3FF));
  endfunction

  // One random character or fault. Most picks are well formed text, with
  // surrogate pairs weighted up since they exercise the held state; the
  // rest are raw noise, stray low surrogates, doubled highs, highs dropped
  // by a plain unit, and highs cut off by the start of a new string.
  task automatic send_random_char();
    int unsigned pick;
    logic        opens;
    pick  = $urandom_range(19);
    opens = ($urandom_range(15) == 0);
    if (pick <= 4) begin
      send_unit(16'($urandom_range(16'h007F)), opens);
    end else if (pick <= 7) begin
      send_unit(16'($urandom_range(16'h0080, 16'h07FF)), opens);
    end else if (pick <= 10) begin
      send_unit(rand_bmp3(), opens);
    end else if (pick <= 14) begin
      send_unit(rand_high(), opens);
      send_unit(rand_low(), 1'b0);
    end else if (pick == 15) begin
      send_unit(16'($urandom_range(16'hFFFF)), opens);
    end else if (pick == 16) begin
      send_unit(rand_low(), opens);
    end else if (pick == 17) begin
      send_unit(rand_high(), opens);
      send_unit(rand_high(), 1'b0);
    end else if (pick == 18) begin
      send_unit(rand_high(), opens);
      send_unit(($urandom_range(1) == 0) ? 16'($urandom_range(16'h007F)) : rand_bmp3(),
                1'b0);
    end else begin
      send_unit(rand_high(), opens);
      send_unit(16'($urandom_range(16'hFFFF)), 1'b1);
    end
  endtask

  initial begin
    rst               = 1'b1;
    unit_if.valid     = 1'b0;
    unit_if.code_unit = '0;
    unit_if.first     = 1'b0;
    send_idle         = 13;
    recv_idle         = 63;
    units_sent        = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: the UTF-8 length boundaries, the ends of the BMP
    // around the surrogate window, the smallest and largest supplementary
    // code points, and every way a surrogate can go astray.
    send_unit(16'h0000, 1'b1);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hD800, 1'b0);   // lowest pair, U+10000
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);   // highest pair, U+10FFFF
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hD800, 1'b0);   // high after high: one error beat
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDC00, 1'b0);   // the second high was not held, so stray low
    send_unit(16'hD812, 1'b0);   // held high silently dropped by a plain unit
    send_unit(16'h0041, 1'b0);
    send_unit(16'hDFFF, 1'b0);   // lone low at the top of the range
    send_unit(16'hDB00, 1'b0);   // held high dropped by a new string
    send_unit(16'h0042, 1'b1);
    send_unit(16'hDA55, 1'b0);   // new string also forgets the high, so the
    send_unit(16'hDE01, 1'b1);   // following low stands alone
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b0);

    // Let everything drain with the sender parked before random traffic.
    wait_drained();

    // Three pacing mixes: slow receiver, slow sender, then full speed.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 13 : (phase == 1) ? 63 : 0;
      recv_idle = (phase == 0) ? 63 : (phase == 1) ? 13 : 0;
      while (units_sent < 24 + 75 * (phase + 1)) send_random_char();
      wait_drained();
    end

    // All stimulus is in; keep watching the output so that a stray beat
    // would show up, then judge.
    repeat (12) @(negedge clk);

    $display("Run drove %0d code units: length boundaries, surrogate pairs, faults and restarts",
             units_sent);
    $display("under slow-receiver, slow-sender and full-rate pacing; %0d beats checked, %0d errors.",
             beats_checked, error_beats);
    if (miss_count == 0 && backlog == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
